>>> rtl/core/dss_pkg.sv
// Shared operation codes, status codes and types for the dual stack block.
package dss_pkg;

	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_PUSH = 2'd0;
	localparam mode_t MODE_POP  = 2'd1;
	localparam mode_t MODE_DUMP = 2'd2;

	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_OVERFLOW = 2'd1;
	localparam status_t STAT_EMPTY    = 2'd2;

endpackage

>>> rtl/core/dss_if.sv
// Valid/ready channel interfaces for the request and response sides of the dual stack block.
interface dss_req_if
	import dss_pkg::*;
	#(parameter int DATA_WIDTH = 32) ();

	logic                         valid;
	logic                         ready;
	mode_t                        mode;
	logic                         stack_sel;
	logic signed [DATA_WIDTH-1:0] data_in;

	modport source(output valid, mode, stack_sel, data_in, input ready);
	modport sink(input valid, mode, stack_sel, data_in, output ready);

endinterface

interface dss_rsp_if
	import dss_pkg::*;
	#(parameter int DATA_WIDTH = 32) ();

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] data_out;
	status_t                      status;
	logic                         last;

	modport source(output valid, data_out, status, last, input ready);
	modport sink(input valid, data_out, status, last, output ready);

endinterface

>>> rtl/core/dss_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/dss_ctrl.sv
// Stack pointers, request sequencing and output register for the dual stack block.
module dss_ctrl
	import dss_pkg::*;
	#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	dss_req_if.sink                  req,
	dss_rsp_if.source                rsp,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [DATA_WIDTH-1:0]    ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  logic [DATA_WIDTH-1:0]    ram_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           low_count_q;
	logic [CW-1:0]           high_count_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           n_q;
	logic                    sel_q;
	logic                    rd_pend_q;
	logic                    pend_last_q;
	logic                    out_valid_q;
	logic [DATA_WIDTH-1:0]   data_q;
	status_t                 status_q;
	logic                    last_q;

	logic                    out_free;
	logic                    accept;
	logic [CW:0]             used_cnt;
	logic                    full;
	logic [CW-1:0]           sel_cnt;
	logic [CW-1:0]           low_top;
	logic [CW-1:0]           high_top;
	logic [CW-1:0]           high_push;
	logic [CW-1:0]           high_bottom;
	logic [CW-1:0]           dump_addr;
	logic [CW-1:0]           idx_next;
	logic                    load;
	logic                    issue;
	logic                    res_set;

	assign out_free    = !out_valid_q || rsp.ready;
	assign req.ready   = (state_q == ST_IDLE) && out_free;
	assign accept      = req.valid && req.ready;
	assign used_cnt    = {1'b0, low_count_q} + {1'b0, high_count_q};
	assign full        = used_cnt >= {1'b0, DEPTH_C};
	assign sel_cnt     = req.stack_sel ? high_count_q : low_count_q;
	assign low_top     = low_count_q - ONE_C;
	assign high_top    = DEPTH_C - high_count_q;
	assign high_push   = DEPTH_C - ONE_C - high_count_q;
	assign high_bottom = DEPTH_C - ONE_C;
	assign dump_addr   = sel_q ? (DEPTH_C - ONE_C - idx_q) : idx_q;
	assign idx_next    = idx_q + ONE_C;
	assign load        = (state_q == ST_DUMP) && rd_pend_q && out_free;
	assign issue       = (state_q == ST_DUMP) && (idx_q != n_q) && (!rd_pend_q || load);
	assign res_set     = load || (accept && ((req.mode == MODE_PUSH) ||
		(((req.mode == MODE_POP) || (req.mode == MODE_DUMP)) && (sel_cnt == '0))));

	assign rsp.valid    = out_valid_q;
	assign rsp.data_out = data_q;
	assign rsp.status   = status_q;
	assign rsp.last     = last_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = low_count_q[AW-1:0];
		ram_wdata = req.data_in;
		ram_re    = 1'b0;
		ram_raddr = dump_addr[AW-1:0];
		if (accept) begin
			case (req.mode)
				MODE_PUSH: begin
					ram_we    = !full;
					ram_waddr = req.stack_sel ? high_push[AW-1:0] : low_count_q[AW-1:0];
				end
				MODE_POP: begin
					ram_re    = sel_cnt != '0;
					ram_raddr = req.stack_sel ? high_top[AW-1:0] : low_top[AW-1:0];
				end
				MODE_DUMP: begin
					ram_re    = sel_cnt != '0;
					ram_raddr = req.stack_sel ? high_bottom[AW-1:0] : '0;
				end
				default: begin
					ram_re = 1'b0;
				end
			endcase
		end else if (issue) begin
			ram_re = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			low_count_q  <= '0;
			high_count_q <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			sel_q        <= 1'b0;
			rd_pend_q    <= 1'b0;
			pend_last_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.mode)
							MODE_PUSH: begin
								last_q      <= 1'b1;
								if (full) begin
									data_q   <= '0;
									status_q <= STAT_OVERFLOW;
								end else begin
									data_q   <= req.data_in;
									status_q <= STAT_OK;
									if (req.stack_sel) begin
										high_count_q <= high_count_q + ONE_C;
									end else begin
										low_count_q <= low_count_q + ONE_C;
									end
								end
							end
							MODE_POP, MODE_DUMP: begin
								if (sel_cnt == '0) begin
									last_q      <= 1'b1;
									data_q      <= '0;
									status_q    <= STAT_EMPTY;
								end else begin
									state_q   <= ST_DUMP;
									rd_pend_q <= 1'b1;
									sel_q     <= req.stack_sel;
									if (req.mode == MODE_POP) begin
										pend_last_q <= 1'b1;
										idx_q       <= '0;
										n_q         <= '0;
										if (req.stack_sel) begin
											high_count_q <= high_count_q - ONE_C;
										end else begin
											low_count_q <= low_top;
										end
									end else begin
										pend_last_q <= sel_cnt == ONE_C;
										idx_q       <= ONE_C;
										n_q         <= sel_cnt;
									end
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DUMP: begin
					if (load) begin
						data_q      <= ram_rdata;
						status_q    <= STAT_OK;
						last_q      <= pend_last_q;
						if (pend_last_q) begin
							state_q <= ST_IDLE;
						end
					end
					if (issue) begin
						rd_pend_q   <= 1'b1;
						idx_q       <= idx_next;
						pend_last_q <= idx_next == n_q;
					end else if (load) begin
						rd_pend_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		used_cnt <= {1'b0, DEPTH_C})
		else $error("stack counts exceed memory depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_pend_q)
		else $error("read pending while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE) && !ram_re)
		else $error("memory write overlaps a read sequence");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != STAT_OK) |-> (data_q == '0) && last_q)
		else $error("error result carries data or is not last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(load && pend_last_q) |=> (state_q == ST_IDLE))
		else $error("sequence did not end after its last result");

endmodule

>>> rtl/core/dual_stack_shared_memory.sv
// Top level of the dual stack block: two stacks sharing one synchronous RAM.
//
//   Channel  Direction  Payload                         Transfer
//   req      in         mode, stack_sel, data_in        req.valid && req.ready
//   rsp      out        data_out, status, last          rsp.valid && rsp.ready
//
// A push, an overflow or an empty result enters the output register straight from the request;
// an unused mode gives no response. A pop reads the RAM, then the result enters the output register.
// A readout of n elements makes one RAM read per element, pipelined.
// Reset empties both stacks at once; RAM contents are not cleared.
// A stalled rsp holds the output register and pauses the read sequence.
module dual_stack_shared_memory #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	dss_req_if.sink   req,
	dss_rsp_if.source rsp
);

	logic                     ram_we;
	logic [$clog2(DEPTH)-1:0] ram_waddr;
	logic [DATA_WIDTH-1:0]    ram_wdata;
	logic                     ram_re;
	logic [$clog2(DEPTH)-1:0] ram_raddr;
	logic [DATA_WIDTH-1:0]    ram_rdata;

	dss_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	dss_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> tb/sv/dss_result_checker.sv
// Result checker for the dual stack block: predicts every response from accepted requests.
module dss_result_checker
	import dss_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	dss_req_if   req,
	dss_rsp_if   rsp,
	output int   mismatch_count,
	output int   results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [DATA_WIDTH-1:0] data;
		status_t               status;
		logic                  last;
	} stack_result_t;

	logic [DATA_WIDTH-1:0] stack_mem [DEPTH];
	int                    low_depth;
	int                    high_depth;
	stack_result_t         results_due [$];

	initial begin
		mismatch_count = 0;
		results_owed   = 0;
		low_depth      = 0;
		high_depth     = 0;
	end

	function automatic void owe_result(input logic [DATA_WIDTH-1:0] data, input status_t status,
		input logic last);
		stack_result_t r;
		r.data   = data;
		r.status = status;
		r.last   = last;
		results_due.push_back(r);
	endfunction

	function automatic void apply_stack_op(input mode_t op, input logic sel,
		input logic [DATA_WIDTH-1:0] val);
		int depth_now;
		case (op)
			MODE_PUSH: begin
				if (low_depth + high_depth >= DEPTH) begin
					owe_result('0, STAT_OVERFLOW, 1'b1);
				end else begin
					if (!sel) begin
						stack_mem[low_depth] = val;
						low_depth++;
					end else begin
						high_depth++;
						stack_mem[DEPTH - high_depth] = val;
					end
					owe_result(val, STAT_OK, 1'b1);
				end
			end
			MODE_POP: begin
				if (!sel) begin
					if (low_depth == 0) begin
						owe_result('0, STAT_EMPTY, 1'b1);
					end else begin
						low_depth--;
						owe_result(stack_mem[low_depth], STAT_OK, 1'b1);
					end
				end else begin
					if (high_depth == 0) begin
						owe_result('0, STAT_EMPTY, 1'b1);
					end else begin
						owe_result(stack_mem[DEPTH - high_depth], STAT_OK, 1'b1);
						high_depth--;
					end
				end
			end
			MODE_DUMP: begin
				depth_now = sel ? high_depth : low_depth;
				if (depth_now == 0) begin
					owe_result('0, STAT_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < depth_now; i++) begin
						owe_result(sel ? stack_mem[DEPTH - 1 - i] : stack_mem[i], STAT_OK,
							i == depth_now - 1);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected response: data %h status %0d last %0d",
							$realtime, rsp.data_out, rsp.status, rsp.last);
					mismatch_count++;
				end else begin
					want = results_due.pop_front();
					if (rsp.data_out !== want.data || rsp.status !== want.status ||
						rsp.last !== want.last) begin
						if (mismatch_count < 10)
							$display({"%0t: response mismatch: expected data %h status %0d ",
								"last %0d, got data %h status %0d last %0d"}, $realtime,
								want.data, want.status, want.last, rsp.data_out, rsp.status,
								rsp.last);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready)
				apply_stack_op(req.mode, req.stack_sel, req.data_in);
			results_owed = results_due.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the dual stack testbench: clock, reset, request stimulus, response stalls and verdict.
module testbench;
	import dss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int    DEPTH       = 16;
	localparam int    DATA_WIDTH  = 32;
	localparam mode_t MODE_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   mismatch_count;
	int   results_owed;

	logic [DATA_WIDTH-1:0] corner_vals [4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
	int                    idle_by_phase [4] = '{0, 62, 0, 10};
	int                    stall_by_phase [4] = '{0, 0, 62, 10};

	dss_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
	dss_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

	dual_stack_shared_memory #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	dss_result_checker #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.mismatch_count(mismatch_count),
		.results_owed(results_owed)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_request(input mode_t op, input logic sel, input logic [DATA_WIDTH-1:0] val);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.mode      <= op;
		req_ch.stack_sel <= sel;
		req_ch.data_in   <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [DATA_WIDTH-1:0] pick_value();
		if ($urandom_range(7) == 0)
			return corner_vals[$urandom_range(3)];
		return $urandom();
	endfunction

	initial begin
		int    push_weight;
		int    roll;
		mode_t op;
		arst_n           = 1'b0;
		idle_pct         = 0;
		stall_pct        = 0;
		req_ch.valid     = 1'b0;
		req_ch.mode      = MODE_PUSH;
		req_ch.stack_sel = 1'b0;
		req_ch.data_in   = '0;
		rsp_ch.ready     = 1'b0;
		push_weight      = 50;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		send_request(MODE_POP, 1'b0, pick_value());
		send_request(MODE_POP, 1'b1, pick_value());
		send_request(MODE_DUMP, 1'b1, pick_value());
		for (int k = 0; k < DEPTH; k++)
			send_request(MODE_PUSH, k[0], (k < 4) ? corner_vals[k] : $urandom());
		send_request(MODE_PUSH, 1'b0, 32'h5a5a5a5a);
		send_request(MODE_UNUSED, 1'b1, 32'ha5a5a5a5);
		send_request(MODE_DUMP, 1'b0, pick_value());
		send_request(MODE_DUMP, 1'b1, pick_value());
		send_request(MODE_POP, 1'b0, pick_value());
		send_request(MODE_POP, 1'b1, pick_value());

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = idle_by_phase[phase];
			stall_pct <= stall_by_phase[phase];
			for (int k = 0; k < 75; k++) begin
				if (k % 25 == 0)
					push_weight = $urandom_range(1) ? 65 : 30;
				roll = $urandom_range(99);
				if (roll < push_weight)
					op = MODE_PUSH;
				else if (roll < push_weight + (100 - push_weight) * 6 / 10)
					op = MODE_POP;
				else if (roll < 97)
					op = MODE_DUMP;
				else
					op = MODE_UNUSED;
				send_request(op, 1'($urandom_range(1)), pick_value());
			end
		end
		req_ch.valid <= 1'b0;

		while (results_owed != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
